// ----- hdl/bounded_indexed_deque_assert.svh -----
// assertion macros for the bounded indexed deque
`ifndef BOUNDED_INDEXED_DEQUE_ASSERT_SVH
`define BOUNDED_INDEXED_DEQUE_ASSERT_SVH
`ifndef SYNTH
`define BID_ASSERT_IMP(lbl, a, c) lbl: assert property (@(posedge i_clk) \
    disable iff (!i_rst_n) (a) |-> (c)) else $error("bid check failed");
`define BID_ASSERT_NXT(lbl, a, c) lbl: assert property (@(posedge i_clk) \
    disable iff (!i_rst_n) (a) |=> (c)) else $error("bid check failed");
`else
`define BID_ASSERT_IMP(lbl, a, c)
`define BID_ASSERT_NXT(lbl, a, c)
`endif
`endif

// ----- hdl/bid_pkg.sv -----
// ----------------------------------------------------------------------------
// bid_pkg
// types, codes and helpers shared by the deque cells and the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bid_pkg;
    localparam int DEPTH_DEF = 64;
    localparam int MAX_IW = 12;

    localparam logic [3:0] K_PUSH_BACK = 4'd0;
    localparam logic [3:0] K_PUSH_FRONT = 4'd1;
    localparam logic [3:0] K_POP_FRONT = 4'd2;
    localparam logic [3:0] K_POP_BACK = 4'd3;
    localparam logic [3:0] K_INSERT = 4'd4;
    localparam logic [3:0] K_DELETE = 4'd5;
    localparam logic [3:0] K_READ = 4'd6;
    localparam logic [3:0] K_WRITE = 4'd7;
    localparam logic [3:0] K_CLEAR = 4'd8;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD_INDEX = 3'd1;
    localparam logic [2:0] ST_NEW_DROPPED = 3'd2;
    localparam logic [2:0] ST_TAIL_DROPPED = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    localparam logic [1:0] REG_LIMIT = 2'd0;
    localparam logic [1:0] REG_WIDTH = 2'd1;
    localparam logic [1:0] REG_SIGNED = 2'd2;

    typedef enum logic [1:0] {
        CM_NONE = 2'd0,
        CM_INS = 2'd1,
        CM_DEL = 2'd2,
        CM_WR = 2'd3
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
        logic [MAX_IW:0] idx;
        logic [MAX_IW:0] occ;
    } t_cell_cmd;

    typedef struct packed {
        logic [3:0] kind;
        logic signed [31:0] position;
        logic [63:0] new_value;
    } t_bid_in;

    typedef struct packed {
        logic [63:0] read_value;
        logic [2:0] status;
        logic [6:0] element_count;
        logic value_changed;
        logic count_changed;
    } t_bid_out;

    // cut to the configured width, then extend
    function automatic logic [63:0] shape_value(input logic [63:0] raw,
                                                input logic [6:0] vw,
                                                input logic sgn);
        logic [6:0] w;
        logic [63:0] mask;
        logic [63:0] v;
        w = (vw == 7'd0) ? 7'd1 : vw;
        if (w >= 7'd64) begin
            shape_value = raw;
        end else begin
            mask = (64'd1 << w[5:0]) - 64'd1;
            v = raw & mask;
            if (sgn && raw[w[5:0] - 6'd1]) begin
                v = v | ~mask;
            end
            shape_value = v;
        end
    endfunction
endpackage
`default_nettype wire

// ----- hdl/bid_cell.sv -----
// ----------------------------------------------------------------------------
// bid_cell
// one element slot; loads, shifts from a neighbor or holds each cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bid_cell #(
    parameter int IDX = 0
) (
    input  wire logic                i_clk,
    input  wire bid_pkg::t_cell_cmd  i_cmd,
    input  wire logic [63:0]         i_new,
    input  wire logic [63:0]         i_left,
    input  wire logic [63:0]         i_right,
    output logic [63:0]              o_value,
    output logic                     o_diff
);
    import bid_pkg::*;

    localparam logic [MAX_IW:0] MY_IDX = (MAX_IW + 1)'(IDX);

    logic [63:0] r_value;
    logic [63:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_cmd.mode)
            CM_INS: begin
                if (MY_IDX == i_cmd.idx) n_value = i_new;
                else if (MY_IDX > i_cmd.idx) n_value = i_left;
            end
            CM_DEL: begin
                if (MY_IDX >= i_cmd.idx) n_value = i_right;
            end
            CM_WR: begin
                if (MY_IDX == i_cmd.idx) n_value = i_new;
            end
            default: n_value = r_value;
        endcase
    end

    // only occupied slots count as a content change
    assign o_diff = (n_value != r_value) && (MY_IDX < i_cmd.occ);
    assign o_value = r_value;

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end
endmodule
`default_nettype wire

// ----- hdl/bounded_indexed_deque.sv -----
// ----------------------------------------------------------------------------
// bounded_indexed_deque
// bounded deque with indexed insert, delete, read and write on a cell chain
// ----------------------------------------------------------------------------
// an operation is taken when start is high and busy is low; busy then stays
// high for one cycle while the cell row updates, and the result is shown with
// o_done for exactly one cycle in the cycle after that. the command register
// ahead of the cell row holds the operation while the row updates. the receiver
// cannot stall, so results must be taken on the cycle o_done is high.
`timescale 1ns / 1ps
`default_nettype none
module bounded_indexed_deque #(
    parameter int DEPTH = bid_pkg::DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire bid_pkg::t_bid_in  i_cmd,
    output logic                   o_done,
    output bid_pkg::t_bid_out      o_result,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [6:0]        i_cfg_data
);
    import bid_pkg::*;
    `include "bounded_indexed_deque_assert.svh"

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // configuration registers
    logic [6:0] r_limit;
    logic [6:0] r_vwidth;
    logic       r_vsigned;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 7'd64;
            r_vwidth <= 7'd32;
            r_vsigned <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LIMIT: r_limit <= i_cfg_data;
                REG_WIDTH: r_vwidth <= i_cfg_data;
                REG_SIGNED: r_vsigned <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // command register: holds the accepted operation while the row updates
    logic    r_pend;
    t_bid_in r_in;
    wire accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pend <= 1'b0;
        else r_pend <= accept;
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_in <= i_cmd;
    end

    assign busy = r_pend;

    // cell row
    logic [CW-1:0] r_occ;
    logic [CW-1:0] n_occ;
    t_cell_cmd     cell_cmd;
    logic [63:0]   cell_val [DEPTH];
    logic [DEPTH-1:0] cell_diff;
    logic [63:0]   shaped;

    assign shaped = shape_value(r_in.new_value, r_vwidth, r_vsigned);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [63:0] left_v;
        logic [63:0] right_v;
        if (g == 0) begin : g_first
            assign left_v = 64'd0;
        end else begin : g_mid_l
            assign left_v = cell_val[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_v = 64'd0;
        end else begin : g_mid_r
            assign right_v = cell_val[g+1];
        end
        bid_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cell_cmd),
            .i_new   (shaped),
            .i_left  (left_v),
            .i_right (right_v),
            .o_value (cell_val[g]),
            .o_diff  (cell_diff[g])
        );
    end

    // decode of the pending operation
    logic [31:0]   occ32;
    logic [31:0]   lim32;
    logic [31:0]   pos32;
    logic          full;
    logic          pos_neg;
    logic          idx_le;
    logic          idx_lt;
    logic [IW-1:0] n_idx;
    logic [IW-1:0] rd_idx;
    logic          rd_en;
    t_bid_out      n_res;
    logic          full_ins;

    always_comb begin
        occ32 = 32'(r_occ);
        lim32 = (32'(r_limit) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(r_limit);
        pos32 = r_in.position;
        full = occ32 >= lim32;
        pos_neg = pos32[31];
        idx_le = !pos_neg && (pos32 <= occ32);
        idx_lt = !pos_neg && (pos32 < occ32);
        n_idx = pos32[IW-1:0];
        rd_idx = n_idx;
        rd_en = 1'b0;
        full_ins = 1'b0;
        n_occ = r_occ;
        cell_cmd.mode = CM_NONE;
        cell_cmd.idx = (MAX_IW + 1)'(n_idx);
        cell_cmd.occ = (MAX_IW + 1)'(r_occ);
        n_res.read_value = 64'd0;
        n_res.status = ST_OK;
        n_res.value_changed = 1'b0;
        n_res.count_changed = 1'b0;

        case (r_in.kind)
            K_PUSH_BACK: begin
                if (full) begin
                    n_res.status = ST_NEW_DROPPED;
                end else begin
                    cell_cmd.mode = CM_WR;
                    cell_cmd.idx = (MAX_IW + 1)'(r_occ);
                    n_occ = r_occ + CW'(1);
                end
            end
            K_PUSH_FRONT: begin
                if (lim32 == 32'd0) begin
                    n_res.status = ST_NEW_DROPPED;
                end else begin
                    cell_cmd.mode = CM_INS;
                    cell_cmd.idx = '0;
                    if (full) full_ins = 1'b1;
                    else n_occ = r_occ + CW'(1);
                end
            end
            K_POP_FRONT, K_POP_BACK: begin
                if (r_occ == '0) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    rd_en = 1'b1;
                    n_occ = r_occ - CW'(1);
                    if (r_in.kind == K_POP_FRONT) begin
                        rd_idx = '0;
                        cell_cmd.mode = CM_DEL;
                        cell_cmd.idx = '0;
                    end else begin
                        rd_idx = IW'(r_occ - CW'(1));
                    end
                end
            end
            K_INSERT: begin
                if (!idx_le) begin
                    n_res.status = ST_BAD_INDEX;
                end else if (lim32 == 32'd0 || (full && pos32 == occ32)) begin
                    n_res.status = ST_NEW_DROPPED;
                end else begin
                    cell_cmd.mode = CM_INS;
                    if (full) full_ins = 1'b1;
                    else n_occ = r_occ + CW'(1);
                end
            end
            K_DELETE, K_READ: begin
                if (r_occ == '0) begin
                    n_res.status = ST_EMPTY;
                end else if (!idx_lt) begin
                    n_res.status = ST_BAD_INDEX;
                end else if (r_in.kind == K_DELETE) begin
                    cell_cmd.mode = CM_DEL;
                    n_occ = r_occ - CW'(1);
                end else begin
                    rd_en = 1'b1;
                end
            end
            K_WRITE: begin
                if (!idx_le) begin
                    n_res.status = ST_BAD_INDEX;
                end else if (pos32 == occ32) begin
                    if (full) begin
                        n_res.status = ST_NEW_DROPPED;
                    end else begin
                        cell_cmd.mode = CM_WR;
                        n_occ = r_occ + CW'(1);
                    end
                end else begin
                    // overwrite in place, changed only if the value differs
                    cell_cmd.mode = CM_WR;
                    n_res.value_changed = |cell_diff;
                end
            end
            K_CLEAR: begin
                n_occ = '0;
            end
            default: ;
        endcase

        // full insert drops the tail; change only if some slot differs
        if (full_ins) begin
            n_res.status = ST_TAIL_DROPPED;
            n_res.value_changed = |cell_diff;
        end
        if (n_occ != r_occ) begin
            n_res.value_changed = 1'b1;
            n_res.count_changed = 1'b1;
        end
        if (rd_en) n_res.read_value = cell_val[rd_idx];
        n_res.element_count = 7'(n_occ);
        if (!r_pend) cell_cmd.mode = CM_NONE;
    end

    // occupancy and result registers
    t_bid_out r_res;
    logic     r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_pend;
            if (r_pend) r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_result = r_res;

    `BID_ASSERT_NXT(a_accept_busy, accept, busy)
    `BID_ASSERT_NXT(a_busy_done, busy, o_done && !busy)
    `BID_ASSERT_IMP(a_occ_bound, 1'b1, 32'(r_occ) <= 32'(DEPTH))
    `BID_ASSERT_IMP(a_shape_count, o_done && o_result.count_changed,
        o_result.value_changed && o_result.status == ST_OK)
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the bounded indexed deque: a directed table of
// operations, then weighted random operations over several limit, width and
// sign settings; results are checked against a local deque predictor, or for
// typed table rows against the expected result held in the row
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import bid_pkg::*;

    localparam int CELLS = 64;
    localparam int RAND_PER_SET = 84;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_bid_in i_cmd;
    logic o_done;
    t_bid_out o_result;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [6:0] i_cfg_data;

    bounded_indexed_deque dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // predictor state: element cells, occupancy and the three registers
    logic [63:0] deque_cells [CELLS];
    int deque_occ;
    logic [6:0] cfg_limit;
    logic [6:0] cfg_width;
    logic cfg_signed;

    // results still owed by the block, oldest first
    t_bid_out pending_results [$];
    int errors;
    int items_sent;
    int results_seen;
    int settings_used;
    bit gaps_on;

    function automatic logic [63:0] trim_value(input logic [63:0] raw);
        int w;
        logic [63:0] mask;
        logic [63:0] v;
        w = (cfg_width == 7'd0) ? 1 : int'(cfg_width);
        if (w >= 64) return raw;
        mask = (64'd1 << w) - 64'd1;
        v = raw & mask;
        if (cfg_signed && v[w-1]) v = v | ~mask;
        return v;
    endfunction

    function automatic int cap();
        return (int'(cfg_limit) > CELLS) ? CELLS : int'(cfg_limit);
    endfunction

    // position check: non-negative and below (or up to) the bound
    function automatic bit index_ok(input logic [31:0] pos, input int bound, input bit incl);
        if (pos[31]) return 1'b0;
        if (incl) return pos <= bound;
        return pos < bound;
    endfunction

    // insert at n; a full deque loses its tail instead of growing
    function automatic logic [2:0] place_at(input int n, input logic [63:0] v,
                                            inout t_bid_out r);
        logic [63:0] shifted [CELLS];
        int i;
        if (deque_occ >= cap()) begin
            r.value_changed = 1'b0;
            for (i = 0; i < deque_occ; i++) begin
                shifted[i] = (i == n) ? v : deque_cells[(i < n) ? i : i - 1];
                if (shifted[i] != deque_cells[i]) r.value_changed = 1'b1;
            end
            for (i = 0; i < deque_occ; i++) deque_cells[i] = shifted[i];
            return ST_TAIL_DROPPED;
        end
        for (i = deque_occ; i > n; i--) deque_cells[i] = deque_cells[i-1];
        deque_cells[n] = v;
        deque_occ++;
        r.value_changed = 1'b1;
        r.count_changed = 1'b1;
        return ST_OK;
    endfunction

    // applies one operation to the predictor and returns the result it owes
    function automatic t_bid_out apply_op(input t_bid_in c);
        t_bid_out r;
        logic [63:0] v;
        int n;
        int i;
        int lim;
        r = '0;
        r.status = ST_OK;
        v = trim_value(c.new_value);
        lim = cap();
        n = int'(c.position[30:0]);
        case (c.kind)
            K_PUSH_BACK: begin
                if (deque_occ >= lim) begin
                    r.status = ST_NEW_DROPPED;
                end else begin
                    deque_cells[deque_occ] = v;
                    deque_occ++;
                    r.value_changed = 1'b1;
                    r.count_changed = 1'b1;
                end
            end
            K_PUSH_FRONT: begin
                if (lim == 0) r.status = ST_NEW_DROPPED;
                else r.status = place_at(0, v, r);
            end
            K_POP_FRONT, K_POP_BACK: begin
                if (deque_occ == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (c.kind == K_POP_FRONT) begin
                        r.read_value = deque_cells[0];
                        for (i = 0; i + 1 < deque_occ; i++) deque_cells[i] = deque_cells[i+1];
                    end else begin
                        r.read_value = deque_cells[deque_occ-1];
                    end
                    deque_occ--;
                    r.value_changed = 1'b1;
                    r.count_changed = 1'b1;
                end
            end
            K_INSERT: begin
                if (!index_ok(c.position, deque_occ, 1'b1)) r.status = ST_BAD_INDEX;
                else if (lim == 0 || (deque_occ >= lim && n == deque_occ))
                    r.status = ST_NEW_DROPPED;
                else r.status = place_at(n, v, r);
            end
            K_DELETE, K_READ: begin
                if (deque_occ == 0) begin
                    r.status = ST_EMPTY;
                end else if (!index_ok(c.position, deque_occ, 1'b0)) begin
                    r.status = ST_BAD_INDEX;
                end else if (c.kind == K_DELETE) begin
                    for (i = n; i + 1 < deque_occ; i++) deque_cells[i] = deque_cells[i+1];
                    deque_occ--;
                    r.value_changed = 1'b1;
                    r.count_changed = 1'b1;
                end else begin
                    r.read_value = deque_cells[n];
                end
            end
            K_WRITE: begin
                if (!index_ok(c.position, deque_occ, 1'b1)) begin
                    r.status = ST_BAD_INDEX;
                end else if (n == deque_occ) begin
                    // writing one past the end appends
                    if (deque_occ >= lim) begin
                        r.status = ST_NEW_DROPPED;
                    end else begin
                        deque_cells[deque_occ] = v;
                        deque_occ++;
                        r.value_changed = 1'b1;
                        r.count_changed = 1'b1;
                    end
                end else if (deque_cells[n] != v) begin
                    deque_cells[n] = v;
                    r.value_changed = 1'b1;
                end
            end
            K_CLEAR: begin
                if (deque_occ != 0) begin
                    r.value_changed = 1'b1;
                    r.count_changed = 1'b1;
                end
                deque_occ = 0;
            end
            default: ;
        endcase
        r.element_count = 7'(deque_occ);
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    // result checker: the block cannot be stalled, so take every strobe
    always @(posedge i_clk) begin
        t_bid_out want;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report("unexpected result", 64'(o_result.status), 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_result.read_value !== want.read_value)
                    report("read_value", o_result.read_value, want.read_value);
                if (o_result.status !== want.status)
                    report("status", 64'(o_result.status), 64'(want.status));
                if (o_result.element_count !== want.element_count)
                    report("element_count", 64'(o_result.element_count),
                           64'(want.element_count));
                if (o_result.value_changed !== want.value_changed)
                    report("value_changed", 64'(o_result.value_changed),
                           64'(want.value_changed));
                if (o_result.count_changed !== want.count_changed)
                    report("count_changed", 64'(o_result.count_changed),
                           64'(want.count_changed));
            end
        end
    end

    // occasional random hold-off on the command side while gaps_on is set
    task automatic maybe_gap();
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // one command transfer; start stays high if the next one follows at once
    task automatic send_op(input t_bid_in c, input bit typed, input t_bid_out typed_res);
        t_bid_out predicted;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (!(start === 1'b1 && busy === 1'b0));
        predicted = apply_op(c);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
        items_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // valid stays high across back-to-back register writes
    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!(i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1));
        case (idx)
            REG_LIMIT: cfg_limit = val;
            REG_WIDTH: cfg_width = val;
            REG_SIGNED: cfg_signed = val[0];
            default: ;
        endcase
    endtask

    function automatic t_bid_in random_op();
        t_bid_in c;
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) c.kind = K_PUSH_BACK;
        else if (r < 30) c.kind = K_PUSH_FRONT;
        else if (r < 38) c.kind = K_POP_FRONT;
        else if (r < 45) c.kind = K_POP_BACK;
        else if (r < 58) c.kind = K_INSERT;
        else if (r < 66) c.kind = K_DELETE;
        else if (r < 76) c.kind = K_READ;
        else if (r < 88) c.kind = K_WRITE;
        else if (r < 91) c.kind = K_CLEAR;
        else c.kind = 4'($urandom_range(9, 15));
        r = $urandom_range(0, 9);
        if (r < 6) c.position = $urandom_range(0, deque_occ + 1);
        else if (r < 8) c.position = $urandom;
        else if (r == 8) c.position = -$urandom_range(1, 3);
        else c.position = 32'h7fff_ffff;
        r = $urandom_range(0, 9);
        if (r < 6) c.new_value = {$urandom, $urandom};
        else if (r < 8) c.new_value = 64'($urandom_range(0, 3));
        else if (r == 8) c.new_value = '1;
        // reuse a stored value so equal writes and no-change shifts occur
        else c.new_value = (deque_occ == 0) ? 64'd0 : deque_cells[$urandom_range(0, deque_occ-1)];
        return c;
    endfunction

    typedef struct {
        t_bid_in cmd;
        bit typed;
        t_bid_out res;
    } t_row;

    function automatic t_row row(input logic [3:0] k, input logic [31:0] p,
                                 input logic [63:0] v, input bit typed,
                                 input logic [2:0] st, input int cnt);
        t_row x;
        x.cmd.kind = k;
        x.cmd.position = p;
        x.cmd.new_value = v;
        x.typed = typed;
        x.res = '0;
        x.res.status = st;
        x.res.element_count = 7'(cnt);
        return x;
    endfunction

    // limit, width, signed for each random phase; extremes included
    logic [6:0] set_limit [9] = '{7'd4, 7'd0, 7'd127, 7'd2, 7'd8, 7'd1, 7'd64, 7'd3, 7'd64};
    logic [6:0] set_width [9] = '{7'd1, 7'd64, 7'd0, 7'd63, 7'd7, 7'd64, 7'd13, 7'd33, 7'd64};
    logic set_sign [9] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

    initial begin
        t_row table_rows [$];
        int i;
        int s;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        settings_used = 1;
        gaps_on = 1'b1;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        deque_occ = 0;
        cfg_limit = 7'd64;
        cfg_width = 7'd32;
        cfg_signed = 1'b0;
        for (i = 0; i < CELLS; i++) deque_cells[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, reset settings: empty cases, bad indexes, each kind
        table_rows = {table_rows, row(K_POP_FRONT, 0, 0, 1, ST_EMPTY, 0)};
        table_rows = {table_rows, row(K_POP_BACK, 0, 0, 1, ST_EMPTY, 0)};
        table_rows = {table_rows, row(K_READ, 0, 0, 1, ST_EMPTY, 0)};
        table_rows = {table_rows, row(K_DELETE, 0, 0, 1, ST_EMPTY, 0)};
        table_rows = {table_rows, row(K_WRITE, 1, 64'd9, 1, ST_BAD_INDEX, 0)};
        table_rows = {table_rows, row(K_INSERT, 32'hffff_ffff, 64'd9, 1, ST_BAD_INDEX, 0)};
        table_rows = {table_rows, row(K_PUSH_BACK, 0, '1, 0, ST_OK, 0)};
        table_rows = {table_rows, row(K_PUSH_FRONT, 0, 64'd0, 0, ST_OK, 0)};
        table_rows = {table_rows, row(K_INSERT, 1, 64'h8000_0000_8000_0005, 0, ST_OK, 0)};
        table_rows = {table_rows, row(K_READ, 32'h7fff_ffff, 0, 1, ST_BAD_INDEX, 3)};
        table_rows = {table_rows, row(K_READ, 32'h8000_0000, 0, 1, ST_BAD_INDEX, 3)};
        table_rows = {table_rows, row(K_READ, 2, 0, 0, ST_OK, 0)};
        table_rows = {table_rows, row(K_WRITE, 0, 64'd0, 0, ST_OK, 0)};
        table_rows = {table_rows, row(K_WRITE, 3, 64'hdead_beef_cafe_f00d, 0, ST_OK, 0)};
        table_rows = {table_rows, row(K_WRITE, 4, 64'd1, 0, ST_OK, 0)};
        table_rows = {table_rows, row(K_DELETE, 1, 0, 0, ST_OK, 0)};
        table_rows = {table_rows, row(K_POP_BACK, 0, 0, 0, ST_OK, 0)};
        table_rows = {table_rows, row(K_POP_FRONT, 0, 0, 0, ST_OK, 0)};
        table_rows = {table_rows, row(4'd9, 32'hffff_ffff, '1, 0, ST_OK, 0)};
        table_rows = {table_rows, row(4'd15, 0, '1, 0, ST_OK, 0)};
        table_rows = {table_rows, row(K_CLEAR, 0, 0, 0, ST_OK, 0)};
        table_rows = {table_rows, row(K_CLEAR, 0, 0, 1, ST_OK, 0)};
        foreach (table_rows[i]) begin
            send_op(table_rows[i].cmd, table_rows[i].typed, table_rows[i].res);
            maybe_gap();
        end
        drain();

        // random phases, each under its own register settings
        for (s = 0; s < 9; s++) begin
            write_reg(REG_LIMIT, set_limit[s]);
            write_reg(REG_WIDTH, set_width[s]);
            write_reg(REG_SIGNED, {6'd0, set_sign[s]});
            i_cfg_valid <= 1'b0;
            settings_used++;
            gaps_on = (s != 8);
            for (i = 0; i < RAND_PER_SET; i++) begin
                send_op(random_op(), 1'b0, '0);
                // hold off once until every owed result is back
                if (s == 4 && i == RAND_PER_SET / 2) drain();
                maybe_gap();
            end
            drain();
        end

        $display("ran %0d operations over %0d register settings, %0d results checked",
                 items_sent, settings_used, results_seen);
        $display("limits 0 to 127, widths 0 to 64, both sign modes, all nine kinds");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
